/* src/hog_acc_pkg.sv */
// Shared types and constants for the HOG block histogram accumulator.
package hog_acc_pkg;

    localparam int HIST_DEPTH   = 128;
    localparam int BLOCK_PIXELS = 256;
    localparam int SLOTS        = 4;

    localparam int CMD_W     = 2;
    localparam int PIXEL_W   = 8;
    localparam int SLOT_W    = 2;
    localparam int WEIGHT_W  = 17;
    localparam int OFFSET_W  = 7;
    localparam int VOTE_W    = 11;
    localparam int CHAN_W    = 5;
    localparam int BIDX_W    = 7;
    localparam int BIN_VAL_W = 40;
    localparam int LEN_W     = 8;

    localparam int ENTRY_W = WEIGHT_W + OFFSET_W;
    localparam int BIN_W   = OFFSET_W + 1;
    localparam int PROD_W  = WEIGHT_W + VOTE_W;
    localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int PIX_AW  = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
    localparam int WT_AW   = PIX_AW + SLOT_W;
    localparam int WT_DEPTH = BLOCK_PIXELS * SLOTS;

    localparam logic [LEN_W-1:0]     LEN_RESET = LEN_W'(128);
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [BIN_VAL_W-1:0] BIN_MAX   = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ACCUM = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                 command;
        logic [PIXEL_W-1:0]   pixel_index;
        logic [SLOT_W-1:0]    slot;
        logic [WEIGHT_W-1:0]  weight;
        logic [OFFSET_W-1:0]  bin_offset;
        logic [VOTE_W-1:0]    vote_first;
        logic [CHAN_W-1:0]    chan_first;
        logic [VOTE_W-1:0]    vote_second;
        logic [CHAN_W-1:0]    chan_second;
        logic [BIDX_W-1:0]    bin_index;
    } in_t;

    typedef struct packed {
        logic [BIN_VAL_W-1:0] bin_value;
        logic                 index_dropped;
        logic                 saturated;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_DATA,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [WT_AW-1:0] addr;
    } wtab_cmd_t;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic               wr_en;
        logic [HIST_AW-1:0] addr;
    } hist_cmd_t;

endpackage

/* src/hog_acc_wtab.sv */
// Spatial weight table: four weight/offset slots per block pixel, registered read.
module hog_acc_wtab (
    input  logic                                aclk,
    input  hog_acc_pkg::wtab_cmd_t              cmd,
    input  logic [hog_acc_pkg::ENTRY_W-1:0]     wr_data,
    output logic [hog_acc_pkg::ENTRY_W-1:0]     rd_data
);
    import hog_acc_pkg::*;

    logic [ENTRY_W-1:0] mem [WT_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/hog_acc_hist.sv */
// Histogram bin store: single-port memory with per-bin valid bits so that a clear empties every bin at once.
module hog_acc_hist (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hog_acc_pkg::hist_cmd_t              cmd,
    input  logic [hog_acc_pkg::BIN_VAL_W-1:0]   wr_data,
    output logic [hog_acc_pkg::BIN_VAL_W-1:0]   rd_data
);
    import hog_acc_pkg::*;

    logic [BIN_VAL_W-1:0]  mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] valid_reg;
    logic [BIN_VAL_W-1:0]  rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear) begin
            valid_reg <= '0;
        end else if (cmd.wr_en) begin
            valid_reg[cmd.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[cmd.addr];
            rd_valid_reg <= valid_reg[cmd.addr];
        end
    end

    // A bin never written since reset or clear reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/hog_acc_mac.sv */
// Shared multiply-accumulate unit: registered weight*vote, saturating add onto a bin.
module hog_acc_mac (
    input  logic                                aclk,
    input  logic                                load,
    input  logic [hog_acc_pkg::WEIGHT_W-1:0]    weight,
    input  logic [hog_acc_pkg::VOTE_W-1:0]      vote,
    input  logic [hog_acc_pkg::BIN_VAL_W-1:0]   addend,
    output logic [hog_acc_pkg::BIN_VAL_W-1:0]   sum,
    output logic                                sat
);
    import hog_acc_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [BIN_VAL_W:0]   wide_sum;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(weight) * PROD_W'(vote);
        end
    end

    always_comb begin
        wide_sum = {1'b0, addend} + (BIN_VAL_W + 1)'(prod_reg);
        sat      = wide_sum[BIN_VAL_W];
        sum      = sat ? BIN_MAX : wide_sum[BIN_VAL_W-1:0];
    end

endmodule

/* src/hog_block_histogram_accumulate_core.sv */
// HOG block histogram accumulator: sequencer around one shared multiply-accumulate unit.
// Clear and weight write go from EXEC to DONE, a read passes through RD_DATA; an accumulate
// visits MUL once per slot of zero weight, else once per channel update, and ACC for each
// update that is not dropped. One item at a time; the next is taken the cycle after the result loads.
// The single-port bin memory sets the pace: each update is one read and one write.
// Reset: hist_length 128, all bins read zero (valid bits cleared), weight table undefined.
module hog_block_histogram_accumulate_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hog_acc_pkg::LEN_W-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hog_acc_pkg::in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hog_acc_pkg::out_t                 m_data
);
    import hog_acc_pkg::*;

    state_t               state_reg, state_next;
    in_t                  item_reg, item_next;
    logic [LEN_W-1:0]     hist_length_reg, hist_length_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 chan_sel_reg, chan_sel_next;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [BIN_VAL_W-1:0] value_reg, value_next;
    logic                 drop_reg, drop_next;
    logic                 sat_reg, sat_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    wtab_cmd_t            wt_cmd;
    logic [ENTRY_W-1:0]   wt_wdata;
    logic [ENTRY_W-1:0]   wt_rdata;
    hist_cmd_t            hist_cmd;
    logic [BIN_VAL_W-1:0] hist_rdata;
    logic                 mac_load;
    logic [VOTE_W-1:0]    mac_vote;
    logic [BIN_VAL_W-1:0] mac_sum;
    logic                 mac_sat;

    logic [WEIGHT_W-1:0]  entry_weight;
    logic [OFFSET_W-1:0]  entry_offset;
    logic [CHAN_W-1:0]    cur_chan;
    logic [BIN_W-1:0]     bin_calc;
    logic                 bin_ok;
    logic                 pix_ok;
    logic                 bidx_ok;
    logic [PIX_AW-1:0]    pix_addr;
    logic                 adv_slot;

    hog_acc_wtab u_wtab (
        .aclk    (aclk),
        .cmd     (wt_cmd),
        .wr_data (wt_wdata),
        .rd_data (wt_rdata)
    );

    hog_acc_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hist_cmd),
        .wr_data (mac_sum),
        .rd_data (hist_rdata)
    );

    hog_acc_mac u_mac (
        .aclk   (aclk),
        .load   (mac_load),
        .weight (entry_weight),
        .vote   (mac_vote),
        .addend (hist_rdata),
        .sum    (mac_sum),
        .sat    (mac_sat)
    );

    assign entry_weight = wt_rdata[ENTRY_W-1:OFFSET_W];
    assign entry_offset = wt_rdata[OFFSET_W-1:0];
    assign cur_chan     = chan_sel_reg ? item_reg.chan_second : item_reg.chan_first;
    assign mac_vote     = chan_sel_reg ? item_reg.vote_second : item_reg.vote_first;
    assign bin_calc     = BIN_W'(entry_offset) + BIN_W'(cur_chan);
    assign bin_ok       = (32'(bin_calc) < 32'(hist_length_reg))
                       && (32'(bin_calc) < 32'(HIST_DEPTH));
    assign pix_ok       = 32'(item_reg.pixel_index) < 32'(BLOCK_PIXELS);
    assign bidx_ok      = 32'(item_reg.bin_index) < 32'(HIST_DEPTH);
    assign pix_addr     = PIX_AW'(item_reg.pixel_index);
    assign wt_wdata     = {item_reg.weight, item_reg.bin_offset};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            hist_length_reg <= LEN_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            hist_length_reg <= hist_length_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        slot_reg     <= slot_next;
        chan_sel_reg <= chan_sel_next;
        bin_reg      <= bin_next;
        value_reg    <= value_next;
        drop_reg     <= drop_next;
        sat_reg      <= sat_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        hist_length_next = cfg_wr_en ? cfg_wr_data : hist_length_reg;
        slot_next        = slot_reg;
        chan_sel_next    = chan_sel_reg;
        bin_next         = bin_reg;
        value_next       = value_reg;
        drop_next        = drop_reg;
        sat_next         = sat_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        wt_cmd           = '0;
        hist_cmd         = '0;
        mac_load         = 1'b0;
        adv_slot         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                value_next    = '0;
                drop_next     = 1'b0;
                sat_next      = 1'b0;
                slot_next     = '0;
                chan_sel_next = 1'b0;
                state_next    = ST_DONE;
                unique case (item_reg.command)
                    CMD_CLEAR: begin
                        hist_cmd.clear = 1'b1;
                    end
                    CMD_WRITE: begin
                        wt_cmd.wr_en = pix_ok;
                        wt_cmd.addr  = {pix_addr, item_reg.slot};
                    end
                    CMD_ACCUM: begin
                        if (pix_ok) begin
                            wt_cmd.rd_en = 1'b1;
                            wt_cmd.addr  = {pix_addr, SLOT_W'(0)};
                            state_next   = ST_MUL;
                        end
                    end
                    CMD_READ: begin
                        if (bidx_ok) begin
                            hist_cmd.rd_en = 1'b1;
                            hist_cmd.addr  = HIST_AW'(item_reg.bin_index);
                            state_next     = ST_RD_DATA;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_DATA: begin
                value_next = hist_rdata;
                state_next = ST_DONE;
            end
            ST_MUL: begin
                if (entry_weight == '0) begin
                    adv_slot = 1'b1;
                end else begin
                    mac_load = 1'b1;
                    bin_next = bin_calc;
                    if (bin_ok) begin
                        hist_cmd.rd_en = 1'b1;
                        hist_cmd.addr  = HIST_AW'(bin_calc);
                        state_next     = ST_ACC;
                    end else begin
                        // Drop this update, keep the rest of the item.
                        drop_next = 1'b1;
                        if (chan_sel_reg) begin
                            adv_slot = 1'b1;
                        end else begin
                            chan_sel_next = 1'b1;
                        end
                    end
                end
            end
            ST_ACC: begin
                hist_cmd.wr_en = 1'b1;
                hist_cmd.addr  = HIST_AW'(bin_reg);
                sat_next       = sat_reg | mac_sat;
                if (chan_sel_reg) begin
                    adv_slot = 1'b1;
                end else begin
                    chan_sel_next = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.bin_value     = value_reg;
                    m_data_next.index_dropped = drop_reg;
                    m_data_next.saturated     = sat_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next weight slot, or finish after the last; its entry arrives for the next MUL cycle.
        if (adv_slot) begin
            chan_sel_next = 1'b0;
            if (slot_reg == LAST_SLOT) begin
                state_next = ST_DONE;
            end else begin
                slot_next    = slot_reg + SLOT_W'(1);
                wt_cmd.rd_en = 1'b1;
                wt_cmd.addr  = {pix_addr, slot_reg + SLOT_W'(1)};
                state_next   = ST_MUL;
            end
        end
    end

endmodule

/* sim/hog_histogram_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the HOG histogram accumulator: mirrors bins and weight slots, checks each result.
module hog_histogram_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hog_acc_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  hog_acc_pkg::in_t              s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  hog_acc_pkg::out_t             m_data,
    output int                            mismatch_count,
    output int                            results_pending
);
    import hog_acc_pkg::*;

    logic [BIN_VAL_W-1:0] bin_model   [HIST_DEPTH];
    logic [WEIGHT_W-1:0]  slot_weight [WT_DEPTH];
    logic [OFFSET_W-1:0]  slot_offset [WT_DEPTH];
    logic [LEN_W-1:0]     active_length;
    out_t                 expected_q [$];
    int                   failures = 0;

    // Add one product to a bin; drop it past the active length, clip at full scale.
    function automatic void add_to_bin(input int unsigned bin, input logic [PROD_W-1:0] amount,
                                       inout logic dropped, inout logic clipped);
        int unsigned        limit;
        logic [BIN_VAL_W:0] sum;
        limit = (active_length > HIST_DEPTH) ? HIST_DEPTH : active_length;
        if (bin >= limit) begin
            dropped = 1'b1;
        end else begin
            sum = {1'b0, bin_model[bin]} + (BIN_VAL_W + 1)'(amount);
            if (sum[BIN_VAL_W]) begin
                sum     = {1'b0, BIN_MAX};
                clipped = 1'b1;
            end
            bin_model[bin] = sum[BIN_VAL_W-1:0];
        end
    endfunction

    function automatic out_t predict_result(input in_t item);
        out_t              res;
        int unsigned       entry;
        logic              dropped;
        logic              clipped;
        logic [PROD_W-1:0] amount;
        res     = '0;
        dropped = 1'b0;
        clipped = 1'b0;
        unique case (item.command)
            CMD_CLEAR: begin
                for (int b = 0; b < HIST_DEPTH; b++) bin_model[b] = '0;
            end
            CMD_WRITE: begin
                if (item.pixel_index < BLOCK_PIXELS) begin
                    entry              = item.pixel_index * SLOTS + item.slot;
                    slot_weight[entry] = item.weight;
                    slot_offset[entry] = item.bin_offset;
                end
            end
            CMD_ACCUM: begin
                if (item.pixel_index < BLOCK_PIXELS) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        entry = item.pixel_index * SLOTS + s;
                        if (slot_weight[entry] != '0) begin
                            amount = PROD_W'(slot_weight[entry]) * PROD_W'(item.vote_first);
                            add_to_bin(int'(slot_offset[entry]) + int'(item.chan_first), amount,
                                       dropped, clipped);
                            amount = PROD_W'(slot_weight[entry]) * PROD_W'(item.vote_second);
                            add_to_bin(int'(slot_offset[entry]) + int'(item.chan_second), amount,
                                       dropped, clipped);
                        end
                    end
                end
            end
            CMD_READ: begin
                if (item.bin_index < HIST_DEPTH) res.bin_value = bin_model[item.bin_index];
            end
            default: ;
        endcase
        res.index_dropped = dropped;
        res.saturated     = clipped;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            for (int b = 0; b < HIST_DEPTH; b++) bin_model[b] = '0;
            for (int e = 0; e < WT_DEPTH; e++) begin
                slot_weight[e] = '0;
                slot_offset[e] = '0;
            end
            active_length = LEN_RESET;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %0h dropped %0b sat %0b",
                             $time, m_data.bin_value, m_data.index_dropped, m_data.saturated);
                    failures++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.bin_value !== want.bin_value) begin
                        $display("%0t: bin_value expected %0h, got %0h",
                                 $time, want.bin_value, m_data.bin_value);
                        failures++;
                    end
                    if (m_data.index_dropped !== want.index_dropped) begin
                        $display("%0t: index_dropped expected %0b, got %0b",
                                 $time, want.index_dropped, m_data.index_dropped);
                        failures++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.saturated, m_data.saturated);
                        failures++;
                    end
                end
            end
            if (cfg_wr_en) begin
                active_length = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_result(s_data));
            end
        end
        results_pending <= expected_q.size();
        mismatch_count  <= failures;
    end

endmodule

/* sim/hog_block_histogram_accumulate_core_test.sv */
`timescale 1ns / 1ps
// Testbench top for the HOG histogram accumulator: clock, reset, stimulus, idling and verdict.
module hog_block_histogram_accumulate_core_test;
    import hog_acc_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int SAT_ITEMS    = 520;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_t              s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_t             m_data;
    int               mismatches;
    int               pending;

    int               sender_idle_pct = 0;
    int               stall_pct       = 0;
    int               hold_requests   = 0;
    bit [SLOTS-1:0]   slot_loaded [BLOCK_PIXELS];
    int               loaded_pixels [$];

    hog_block_histogram_accumulate_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    hog_histogram_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatches),
        .results_pending (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus a long counted hold-off whenever one is requested.
    initial begin : result_sink
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input in_t item);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] length);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= length;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct      <= receiver_pct;
    endtask

    // Random payload with the given command; unused fields carry noise.
    function automatic in_t noise_item(input cmd_t command);
        logic [95:0] bits;
        in_t         item;
        bits         = {$urandom, $urandom, $urandom};
        item         = bits[$bits(in_t)-1:0];
        item.command = command;
        return item;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return WEIGHT_W'(1 << 16);
            3:       return WEIGHT_W'($urandom_range(131071, 65537));
            default: return WEIGHT_W'($urandom_range(65535, 1));
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        if ($urandom_range(3) != 0) begin
            return OFFSET_W'($urandom_range(96));
        end
        return OFFSET_W'($urandom);
    endfunction

    function automatic logic [VOTE_W-1:0] pick_vote();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return VOTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(11))
            0:       return '0;
            1:       return LEN_W'(1);
            2:       return LEN_W'(HIST_DEPTH);
            3:       return '1;
            4:       return LEN_W'(HIST_DEPTH - 1);
            default: return LEN_W'($urandom_range(255, 32));
        endcase
    endfunction

    task automatic write_slot(input logic [PIXEL_W-1:0] pixel, input logic [SLOT_W-1:0] slot,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [OFFSET_W-1:0] offset);
        in_t item;
        item             = noise_item(CMD_WRITE);
        item.pixel_index = pixel;
        item.slot        = slot;
        item.weight      = weight;
        item.bin_offset  = offset;
        send_item(item);
        // a pixel becomes usable for accumulation once all its slots hold data
        if (slot_loaded[pixel] != '1) begin
            slot_loaded[pixel][slot] = 1'b1;
            if (slot_loaded[pixel] == '1) loaded_pixels.push_back(pixel);
        end
    endtask

    task automatic accumulate(input logic [PIXEL_W-1:0] pixel,
                              input logic [VOTE_W-1:0] vote_a, input logic [CHAN_W-1:0] chan_a,
                              input logic [VOTE_W-1:0] vote_b, input logic [CHAN_W-1:0] chan_b);
        in_t item;
        item             = noise_item(CMD_ACCUM);
        item.pixel_index = pixel;
        item.vote_first  = vote_a;
        item.chan_first  = chan_a;
        item.vote_second = vote_b;
        item.chan_second = chan_b;
        send_item(item);
    endtask

    task automatic random_accumulate(input logic [PIXEL_W-1:0] pixel);
        accumulate(pixel, pick_vote(), CHAN_W'($urandom), pick_vote(), CHAN_W'($urandom));
    endtask

    task automatic read_bin(input logic [BIDX_W-1:0] index);
        in_t item;
        item           = noise_item(CMD_READ);
        item.bin_index = index;
        send_item(item);
    endtask

    initial begin
        int                 sent;
        int                 roll;
        int                 burst;
        bit                 mid_done;
        logic [PIXEL_W-1:0] pixel;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset contents, slot extremes, drops, length extremes, clear.
        read_bin(0);
        write_slot(0, 0, WEIGHT_W'(1 << 16), 0);
        write_slot(0, 1, 1, '1);
        write_slot(0, 2, 0, 5);
        write_slot(0, 3, '1, 100);
        write_slot('1, 0, 0, 0);
        write_slot('1, 1, 0, '1);
        write_slot('1, 2, WEIGHT_W'(1 << 16), 96);
        write_slot('1, 3, 0, 0);
        accumulate(0, '1, 0, 0, '1);
        accumulate('1, '1, '1, 1, 0);
        read_bin(0);
        read_bin('1);
        read_bin(96);
        read_bin(31);
        send_item(noise_item(CMD_CLEAR));
        read_bin('1);
        set_length('0);
        accumulate(0, 5, 3, 7, 4);
        set_length(1);
        accumulate(0, '1, 0, '1, 0);
        read_bin(0);
        set_length('1);
        accumulate('1, '1, '1, '1, '1);
        read_bin('1);
        send_item(noise_item(CMD_CLEAR));

        // Drive one bin to full scale: all slots of one pixel feed the same bin at max weight and vote.
        set_length(LEN_RESET);
        set_idling(24, 24);
        for (int s = 0; s < SLOTS; s++) write_slot(1, SLOT_W'(s), '1, 3);
        repeat (SAT_ITEMS) accumulate(1, '1, 5, '1, 5);
        read_bin(8);
        send_item(noise_item(CMD_CLEAR));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(79, 0);
                2:       set_idling(0, 79);
                default: set_idling(24, 24);
            endcase
            set_length(pick_length());
            sent     = 0;
            mid_done = 1'b0;
            while (sent < RANDOM_ITEMS / 4) begin
                if (!mid_done && sent >= RANDOM_ITEMS / 8) begin
                    mid_done = 1'b1;
                    set_length(pick_length());
                    // hold the result side off while items keep coming
                    if (phase == 0) hold_requests <= hold_requests + 1;
                end
                roll = $urandom_range(99);
                if (loaded_pixels.size() == 0 || roll < 15) begin
                    pixel = PIXEL_W'($urandom_range(BLOCK_PIXELS - 1));
                    for (int s = 0; s < SLOTS; s++) begin
                        write_slot(pixel, SLOT_W'(s), pick_weight(), pick_offset());
                    end
                    burst = $urandom_range(5, 2);
                    repeat (burst) random_accumulate(pixel);
                    sent += SLOTS + burst;
                end else if (roll < 60) begin
                    random_accumulate(
                        PIXEL_W'(loaded_pixels[$urandom_range(loaded_pixels.size() - 1)]));
                    sent++;
                end else if (roll < 70) begin
                    write_slot(PIXEL_W'($urandom_range(BLOCK_PIXELS - 1)),
                               SLOT_W'($urandom_range(SLOTS - 1)),
                               pick_weight(), pick_offset());
                    sent++;
                end else if (roll < 96) begin
                    read_bin(BIDX_W'($urandom_range(HIST_DEPTH - 1)));
                    sent++;
                end else begin
                    send_item(noise_item(CMD_CLEAR));
                    sent++;
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
